[design/idll_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// idll_pkg: shared types and constants of the indexed doubly linked list
// Action codes, status codes and default sizes.
// ----------------------------------------------------------------------------
package idll_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		ACT_APPEND    = 3'd0,
		ACT_PREPEND   = 3'd1,
		ACT_INSERT    = 3'd2,
		ACT_REMOVE    = 3'd3,
		ACT_READ      = 3'd4,
		ACT_OVERWRITE = 3'd5,
		ACT_SEARCH    = 3'd6,
		ACT_HEAD      = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

endpackage
`default_nettype wire

[design/indexed_doubly_linked_list.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list: doubly linked list held in node memories
// Append, prepend, insert after, remove, read, overwrite, search and head
// report over a fixed pool of nodes with a free chain.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per beat: action, node index and value.
//   m_axis returns exactly one result beat per request: status, value,
//   node index and the entry count after the request.
//   Node data, next links and previous links sit in synchronous memories
//   with registered reads; a request reads what it needs, then writes the
//   new or freed node's links and, in a later state, the neighbor links.
//   States from acceptance to result valid: a failed index check or a
//   search or head report on an empty list goes from the read state to the
//   output; read, overwrite, a full status, a failed node check and an append
//   or prepend into an empty list pass the execute state; a head report reads
//   and compares the head node; insert, remove and the other appends and
//   prepends also pass the link write state; a search reads, then compares,
//   per node visited, up to CAPACITY nodes. One request is in flight at a
//   time; s_axis_tready is high in the idle state only, so the next beat is taken in the cycle after the result leaves.
//   While the receiver stalls, hold the result beat and accept nothing new.
//   Reset: the in-use bits, head, tail and count clear at once. The free
//   chain is an untouched high-water mark plus a stack of freed nodes
//   threaded through next links, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list #(
	parameter int CAPACITY   = idll_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = idll_pkg::DATA_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [2:0] action, [7:3] node_index, [39:8] value
	input  wire logic [39:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [1:0] status, [33:2] value_out, [38:34] index_out, [43:39] entry_count
	output logic [47:0]      m_axis_tdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = 5;

	// Link values carry AW+1 bits: top bit set means none.
	typedef logic [AW:0] link_t;
	localparam link_t NONE_L = {1'b1, {AW{1'b0}}};

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_EXEC, S_W2, S_W3, S_SRCH_RD, S_SRCH_CMP, S_OUT
	} state_t;

	// memories
	logic [DATA_WIDTH-1:0] elem_mem [CAPACITY];
	logic [AW-1:0]         next_mem [CAPACITY];
	logic                  next_nil [CAPACITY];
	logic [AW-1:0]         prev_mem [CAPACITY];
	logic                  prev_nil [CAPACITY];

	state_t                state_q;
	logic [CAPACITY-1:0]   in_use_q;
	link_t                 head_q, tail_q, free_q;
	logic [CW-1:0]         hwm_q;      // nodes below this have been handed out once
	logic [CW-1:0]         count_q;
	idll_pkg::action_t     act_q;
	logic [AW-1:0]         idx_q;
	logic [DATA_WIDTH-1:0] val_q;
	link_t                 n_q;        // newly taken node
	link_t                 after_q, before_q;
	link_t                 cur_q;
	logic [CW-1:0]         steps_q;
	logic [1:0]            st_q;
	logic [DATA_WIDTH-1:0] vout_q;
	link_t                 iout_q;
	link_t                 rd_free_next;

	// memory port requests
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [DATA_WIDTH-1:0] rd_elem;
	link_t                 rd_next, rd_prev;
	logic                  we_e, we_n, we_p;
	logic [AW-1:0]         wa_e, wa_n, wa_p;
	logic [DATA_WIDTH-1:0] wd_e;
	link_t                 wd_n, wd_p;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_elem <= elem_mem[rd_addr];
			rd_next <= {next_nil[rd_addr], next_mem[rd_addr]};
			rd_prev <= {prev_nil[rd_addr], prev_mem[rd_addr]};
		end
		if (we_e) elem_mem[wa_e] <= wd_e;
		if (we_n) begin
			next_mem[wa_n] <= wd_n[AW-1:0];
			next_nil[wa_n] <= wd_n[AW];
		end
		if (we_p) begin
			prev_mem[wa_p] <= wd_p[AW-1:0];
			prev_nil[wa_p] <= wd_p[AW];
		end
	end

	// input decode
	logic [4:0]            in_idx;
	logic                  in_idx_ok;
	assign in_idx    = s_axis_tdata[7:3];
	assign in_idx_ok = !in_idx[4] && ({27'd0, in_idx} < CAPACITY);

	logic full;
	assign full = free_q[AW] && (hwm_q == CW'(CAPACITY));

	// free node to take: freed stack first, else next untouched node
	link_t take_node;
	assign take_node = !free_q[AW] ? free_q : {1'b0, hwm_q[AW-1:0]};

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);

	logic [IW-1:0] iout_ext;
	assign iout_ext = iout_q[AW] ? {IW{1'b1}} : IW'(iout_q[AW-1:0]);

	always_comb begin
		m_axis_tdata        = '0;
		m_axis_tdata[1:0]   = st_q;
		m_axis_tdata[33:2]  = 32'(vout_q);
		m_axis_tdata[38:34] = iout_ext;
		m_axis_tdata[43:39] = 5'(count_q);
	end

	// read address and write port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		we_e = 1'b0; wa_e = n_q[AW-1:0]; wd_e = val_q;
		we_n = 1'b0; wa_n = n_q[AW-1:0]; wd_n = NONE_L;
		we_p = 1'b0; wa_p = n_q[AW-1:0]; wd_p = NONE_L;
		case (state_q)
			S_IDLE: begin
				rd_en   = s_axis_tvalid;
				rd_addr = in_idx[AW-1:0];
			end
			S_SRCH_RD: begin
				rd_en   = 1'b1;
				rd_addr = cur_q[AW-1:0];
			end
			S_EXEC: begin
				case (act_q)
					idll_pkg::ACT_APPEND, idll_pkg::ACT_PREPEND: begin
						if (!full) begin
							we_e = 1'b1; wa_e = take_node[AW-1:0];
							we_n = 1'b1; wa_n = take_node[AW-1:0];
							we_p = 1'b1; wa_p = take_node[AW-1:0];
							if (!head_q[AW] && !tail_q[AW]) begin
								if (act_q == idll_pkg::ACT_APPEND) wd_p = tail_q;
								else wd_n = head_q;
							end
						end
					end
					idll_pkg::ACT_INSERT: begin
						if (in_use_q[idx_q] && !full) begin
							we_e = 1'b1; wa_e = take_node[AW-1:0];
							we_n = 1'b1; wa_n = take_node[AW-1:0]; wd_n = rd_next;
							we_p = 1'b1; wa_p = take_node[AW-1:0];
							wd_p = {1'b0, idx_q};
						end
					end
					idll_pkg::ACT_REMOVE: begin
						if (in_use_q[idx_q]) begin
							// push the node on the freed stack
							we_n = 1'b1; wa_n = idx_q; wd_n = free_q;
							we_p = 1'b1; wa_p = idx_q; wd_p = NONE_L;
						end
					end
					idll_pkg::ACT_OVERWRITE: begin
						if (in_use_q[idx_q]) begin
							we_e = 1'b1; wa_e = idx_q;
						end
					end
					default: ;
				endcase
			end
			S_W2: begin
				// neighbor links; for append or prepend, before_q holds the old tail or head
				case (act_q)
					idll_pkg::ACT_APPEND: begin
						we_n = 1'b1; wa_n = before_q[AW-1:0]; wd_n = n_q;
					end
					idll_pkg::ACT_PREPEND: begin
						we_p = 1'b1; wa_p = before_q[AW-1:0]; wd_p = n_q;
					end
					idll_pkg::ACT_INSERT: begin
						we_n = 1'b1; wa_n = idx_q; wd_n = n_q;
						if (!after_q[AW]) begin
							we_p = 1'b1; wa_p = after_q[AW-1:0]; wd_p = n_q;
						end
					end
					idll_pkg::ACT_REMOVE: begin
						if (!before_q[AW]) begin
							we_n = 1'b1; wa_n = before_q[AW-1:0]; wd_n = after_q;
						end
						if (!after_q[AW]) begin
							we_p = 1'b1; wa_p = after_q[AW-1:0]; wd_p = before_q;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			in_use_q <= '0;
			head_q   <= NONE_L;
			tail_q   <= NONE_L;
			free_q   <= NONE_L;
			hwm_q    <= '0;
			count_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						act_q  <= idll_pkg::action_t'(s_axis_tdata[2:0]);
						idx_q  <= in_idx[AW-1:0];
						val_q  <= s_axis_tdata[8 +: DATA_WIDTH];
						st_q   <= idll_pkg::ST_OK;
						vout_q <= '0;
						iout_q <= NONE_L;
						// an out-of-range index fails every node check
						if (!in_idx_ok) begin
							case (idll_pkg::action_t'(s_axis_tdata[2:0]))
								idll_pkg::ACT_INSERT, idll_pkg::ACT_REMOVE,
								idll_pkg::ACT_READ, idll_pkg::ACT_OVERWRITE:
									st_q <= idll_pkg::ST_INVALID;
								default: ;
							endcase
						end
						state_q <= S_RD;
					end
				end
				S_RD: begin
					// read data lands here; drop to output on a failed index
					if (st_q != idll_pkg::ST_OK) state_q <= S_OUT;
					else if (act_q == idll_pkg::ACT_SEARCH) begin
						cur_q   <= head_q;
						steps_q <= '0;
						state_q <= head_q[AW] ? S_OUT : S_SRCH_RD;
					end else if (act_q == idll_pkg::ACT_HEAD) begin
						if (!head_q[AW]) begin
							idx_q   <= head_q[AW-1:0];
							cur_q   <= head_q;
							iout_q  <= head_q;
							state_q <= S_SRCH_RD;
						end else state_q <= S_OUT;
					end else state_q <= S_EXEC;
				end
				S_SRCH_RD: state_q <= S_SRCH_CMP;
				S_SRCH_CMP: begin
					if (act_q == idll_pkg::ACT_HEAD) begin
						vout_q  <= rd_elem;
						state_q <= S_OUT;
					end else if (rd_elem == val_q) begin
						iout_q  <= cur_q;
						state_q <= S_OUT;
					end else if (rd_next[AW] || (steps_q + 1'b1 == CW'(CAPACITY))) begin
						state_q <= S_OUT;
					end else begin
						cur_q   <= rd_next;
						steps_q <= steps_q + 1'b1;
						state_q <= S_SRCH_RD;
					end
				end
				S_EXEC: begin
					state_q <= S_OUT;
					case (act_q)
						idll_pkg::ACT_APPEND, idll_pkg::ACT_PREPEND,
						idll_pkg::ACT_INSERT: begin
							if (act_q == idll_pkg::ACT_INSERT && !in_use_q[idx_q]) begin
								st_q <= idll_pkg::ST_INVALID;
							end else if (full) begin
								st_q <= idll_pkg::ST_FULL;
							end else begin
								n_q    <= take_node;
								iout_q <= take_node;
								in_use_q[take_node[AW-1:0]] <= 1'b1;
								count_q <= count_q + 1'b1;
								if (!free_q[AW]) free_q <= rd_free_next;
								else hwm_q <= hwm_q + 1'b1;
								after_q  <= rd_next;
								before_q <= (act_q == idll_pkg::ACT_APPEND) ? tail_q : head_q;
								if (act_q == idll_pkg::ACT_INSERT) begin
									if (rd_next[AW]) tail_q <= take_node;
									state_q <= S_W2;
								end else if (head_q[AW] || tail_q[AW]) begin
									head_q <= take_node;
									tail_q <= take_node;
								end else begin
									if (act_q == idll_pkg::ACT_APPEND) tail_q <= take_node;
									else head_q <= take_node;
									state_q <= S_W2;
								end
							end
						end
						idll_pkg::ACT_REMOVE: begin
							if (!in_use_q[idx_q]) st_q <= idll_pkg::ST_INVALID;
							else begin
								vout_q   <= rd_elem;
								iout_q   <= rd_next;
								before_q <= rd_prev;
								after_q  <= rd_next;
								if (rd_prev[AW]) head_q <= rd_next;
								if (rd_next[AW]) tail_q <= rd_prev;
								in_use_q[idx_q] <= 1'b0;
								free_q  <= {1'b0, idx_q};
								count_q <= count_q - 1'b1;
								state_q <= S_W2;
							end
						end
						idll_pkg::ACT_READ, idll_pkg::ACT_OVERWRITE: begin
							if (!in_use_q[idx_q]) st_q <= idll_pkg::ST_INVALID;
							else begin
								vout_q <= rd_elem;
								iout_q <= {1'b0, idx_q};
							end
						end
						default: ;
					endcase
				end
				S_W2: state_q <= S_OUT;
				S_OUT: begin
					if (m_axis_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// next link of the freed-stack top, fetched in the read cycle
	always_ff @(posedge clk) begin
		if (state_q == S_RD)
			rd_free_next <= {next_nil[free_q[AW-1:0]], next_mem[free_q[AW-1:0]]};
	end

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: indexed doubly linked list
// Drives list requests on the slave stream and checks every result beat
// against a behavioral list model kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CAP = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [4:0] NIL = 5'h1f;

	typedef struct packed {
		idll_pkg::status_t status;
		logic [31:0]       value_out;
		logic [4:0]        index_out;
		logic [4:0]        entry_count;
	} list_result_t;

	// Scoreboard: holds its own copy of the list and a queue of expected beats.
	class list_scoreboard;
		logic [31:0] elem [CAP];
		int          nxt [CAP];
		int          prv [CAP];
		bit          used [CAP];
		int          head, tail, free_top, count;
		list_result_t pending [$];
		int          errors;

		function new();
			for (int i = 0; i < CAP; i++) begin
				elem[i] = '0;
				nxt[i] = (i + 1 < CAP) ? i + 1 : -1;
				prv[i] = -1;
				used[i] = 0;
			end
			head = -1; tail = -1; free_top = 0; count = 0; errors = 0;
		endfunction

		function bit valid_node(int i);
			return i >= 0 && i < CAP && used[i];
		endfunction

		function int grab_node(logic [31:0] v);
			int n;
			n = free_top;
			free_top = nxt[n];
			elem[n] = v; prv[n] = -1; nxt[n] = -1; used[n] = 1;
			count++;
			return n;
		endfunction

		// Note one accepted request and queue the result it will produce.
		function void note_request(idll_pkg::action_t act, logic [4:0] idx_raw,
				logic [31:0] v);
			list_result_t r;
			int idx, n, b, a, cur, steps;
			bit full;
			idx = $signed(idx_raw);
			r.status = idll_pkg::ST_OK; r.value_out = '0; r.index_out = NIL;
			full = !(free_top >= 0 && free_top < CAP);
			case (act)
				idll_pkg::ACT_APPEND, idll_pkg::ACT_PREPEND: begin
					if (full) r.status = idll_pkg::ST_FULL;
					else begin
						n = grab_node(v);
						if (head < 0 || tail < 0) begin
							head = n; tail = n;
						end else if (act == idll_pkg::ACT_APPEND) begin
							prv[n] = tail; nxt[tail] = n; tail = n;
						end else begin
							nxt[n] = head; prv[head] = n; head = n;
						end
						r.index_out = 5'(n);
					end
				end
				idll_pkg::ACT_INSERT: begin
					if (!valid_node(idx)) r.status = idll_pkg::ST_INVALID;
					else if (full) r.status = idll_pkg::ST_FULL;
					else begin
						a = nxt[idx];
						n = grab_node(v);
						prv[n] = idx; nxt[n] = a; nxt[idx] = n;
						if (a >= 0) prv[a] = n;
						else tail = n;
						r.index_out = 5'(n);
					end
				end
				idll_pkg::ACT_REMOVE: begin
					if (!valid_node(idx)) r.status = idll_pkg::ST_INVALID;
					else begin
						b = prv[idx]; a = nxt[idx];
						r.value_out = elem[idx];
						if (b >= 0) nxt[b] = a;
						else head = a;
						if (a >= 0) prv[a] = b;
						else tail = b;
						nxt[idx] = free_top; prv[idx] = -1; used[idx] = 0;
						free_top = idx; count--;
						r.index_out = (a >= 0) ? a[4:0] : NIL;
					end
				end
				idll_pkg::ACT_READ, idll_pkg::ACT_OVERWRITE: begin
					if (!valid_node(idx)) r.status = idll_pkg::ST_INVALID;
					else begin
						r.value_out = elem[idx];
						if (act == idll_pkg::ACT_OVERWRITE) elem[idx] = v;
						r.index_out = 5'(idx);
					end
				end
				idll_pkg::ACT_SEARCH: begin
					cur = head; steps = 0;
					while (cur >= 0 && steps < CAP) begin
						if (elem[cur] == v) begin
							r.index_out = 5'(cur);
							break;
						end
						cur = nxt[cur]; steps++;
					end
				end
				default: begin
					if (head >= 0) begin
						r.index_out = 5'(head); r.value_out = elem[head];
					end
				end
			endcase
			r.entry_count = 5'(count);
			pending.push_back(r);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
			errors++;
		endtask

		// Compare one result beat with the oldest expectation.
		task check_result(logic [47:0] beat);
			list_result_t got, want;
			got.status = idll_pkg::status_t'(beat[1:0]);
			got.value_out = beat[33:2];
			got.index_out = beat[38:34];
			got.entry_count = beat[43:39];
			if (pending.size() == 0) begin
				report("unexpected beat", beat[31:0], 32'd0);
				return;
			end
			want = pending.pop_front();
			if (got.status != want.status)
				report("status", 32'(got.status), 32'(want.status));
			if (got.value_out != want.value_out)
				report("value", got.value_out, want.value_out);
			if (got.index_out != want.index_out)
				report("index", 32'(got.index_out), 32'(want.index_out));
			if (got.entry_count != want.entry_count)
				report("count", 32'(got.entry_count), 32'(want.entry_count));
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	// [2:0] action, [7:3] node_index, [39:8] value
	logic [39:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	// [1:0] status, [33:2] value_out, [38:34] index_out, [43:39] entry_count
	logic [47:0] m_axis_tdata;

	list_scoreboard board = new();
	bit quiet_phase = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	logic [31:0] recent_vals [8];

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	indexed_doubly_linked_list dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Sample both streams at the rising edge; note requests, check results.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				board.note_request(idll_pkg::action_t'(s_axis_tdata[2:0]),
					s_axis_tdata[7:3], s_axis_tdata[39:8]);
			if (m_axis_tvalid && m_axis_tready)
				board.check_result(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Receiver: stall in random bursts, never when quiet.
	always @(negedge clk) begin
		if (!arst_n) m_axis_tready <= 0;
		else if (stall_left > 0) begin
			m_axis_tready <= 0;
			stall_left--;
		end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			m_axis_tready <= 0;
			stall_left = $urandom_range(0, 2);
		end else m_axis_tready <= 1;
	end

	// Send one beat and hold it until accepted, with an optional gap first.
	// Returns at the falling edge after the accept with tvalid still high.
	task automatic send_beat(idll_pkg::action_t act, logic [4:0] idx, logic [31:0] v);
		int gap;
		gap = (!quiet_phase && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata <= {v, idx, act};
		s_axis_tvalid <= 1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
	endtask

	// Pick a node: mostly a live one, sometimes any slot, an out-of-range index or none.
	function automatic logic [4:0] pick_node();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) return NIL;
		if (k == 1) return 5'($urandom_range(16, 31));
		if (k < 4) return 5'($urandom_range(0, 15));
		for (int t = 0; t < 8; t++) begin
			int c;
			c = $urandom_range(0, CAP - 1);
			if (board.used[c]) return 5'(c);
		end
		return 5'($urandom_range(0, 15));
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return recent_vals[$urandom_range(0, 7)];
			3: return 32'($urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	initial begin
		idll_pkg::action_t act;
		logic [31:0] v;
		for (int i = 0; i < 8; i++) recent_vals[i] = $urandom;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: empty-list cases, fill to full, edge values, then two removes and a search.
		send_beat(idll_pkg::ACT_HEAD, NIL, 0);
		send_beat(idll_pkg::ACT_SEARCH, NIL, 32'h1234);
		send_beat(idll_pkg::ACT_READ, 5'd0, 0);
		send_beat(idll_pkg::ACT_REMOVE, NIL, 0);
		send_beat(idll_pkg::ACT_INSERT, 5'd20, 0);
		send_beat(idll_pkg::ACT_APPEND, NIL, 32'h8000_0000);
		send_beat(idll_pkg::ACT_PREPEND, NIL, 32'h7fff_ffff);
		send_beat(idll_pkg::ACT_INSERT, 5'd0, 32'hffff_ffff);
		send_beat(idll_pkg::ACT_OVERWRITE, 5'd1, 32'h0000_0000);
		send_beat(idll_pkg::ACT_SEARCH, NIL, 32'hffff_ffff);
		send_beat(idll_pkg::ACT_HEAD, NIL, 0);
		for (int i = 0; i < 14; i++) send_beat(idll_pkg::ACT_APPEND, NIL, 32'(i));
		send_beat(idll_pkg::ACT_APPEND, NIL, 32'h55);
		send_beat(idll_pkg::ACT_INSERT, 5'd3, 32'h66);
		send_beat(idll_pkg::ACT_INSERT, 5'd15, 32'h66);
		send_beat(idll_pkg::ACT_REMOVE, 5'd15, 0);
		send_beat(idll_pkg::ACT_REMOVE, 5'd1, 0);
		send_beat(idll_pkg::ACT_SEARCH, NIL, 32'h7777);
		// Hold off until every outstanding result has come back.
		drain_results();

		for (int n = 0; n < 1150; n++) begin
			if (n == 1000) begin
				drain_results();
				quiet_phase = 1;
			end
			// Bias toward growth or shrinkage to sweep the fill level.
			case ($urandom_range(0, 9))
				0, 1: act = (board.count < 12 || n % 200 < 100) ?
					idll_pkg::ACT_APPEND : idll_pkg::ACT_REMOVE;
				2: act = idll_pkg::ACT_PREPEND;
				3: act = idll_pkg::ACT_INSERT;
				4, 5: act = idll_pkg::ACT_REMOVE;
				6: act = idll_pkg::ACT_READ;
				7: act = idll_pkg::ACT_OVERWRITE;
				8: act = idll_pkg::ACT_SEARCH;
				default: act = idll_pkg::action_t'($urandom_range(0, 7));
			endcase
			v = pick_value();
			recent_vals[$urandom_range(0, 7)] = v;
			send_beat(act, pick_node(), v);
		end

		drain_results();
		repeat (60) @(negedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

[indexed_doubly_linked_list.f]
design/idll_pkg.sv
design/indexed_doubly_linked_list.sv
sim/testbench.sv
